// ===== rtl/core/tohq_pkg.sv =====
`default_nettype none
package tohq_pkg;
    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam logic [1:0] RES_DELIVER = 2'd0;
    localparam logic [1:0] RES_DONE    = 2'd1;
    localparam logic [1:0] RES_FULL    = 2'd2;
    localparam logic [1:0] RES_NOMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  sender_id;
        logic [15:0] message_id;
        logic [31:0] seq_number;
        logic        ready_in;
        logic        kind_in;
        logic [15:0] payload_handle;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_type;
        logic [7:0]  out_sender;
        logic [15:0] out_message;
        logic [31:0] out_seq;
        logic        out_kind;
        logic [15:0] out_payload;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [7:0]  sender;
        logic [15:0] message;
        logic [31:0] seq;
        logic        ready;
        logic        kind;
        logic [15:0] payload;
    } entry_t;
endpackage
`default_nettype wire

// ===== rtl/core/total_order_holdback_queue.sv =====
// remove and update share one compare unit that steps through the list one slot or slot pair
//   per cycle; update then drains the delivered words while the receiver takes them
// throughput: one command at a time, next command taken once the closing status word leaves
// reset: asynchronous active low, queue empty, no word pending
`default_nettype none
module total_order_holdback_queue
    import tohq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t in_data,
    input  wire logic in_valid,
    output logic      in_stall,
    output res_t      out_data,
    output logic      out_valid,
    input  wire logic out_stall
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REM  = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_DRN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    entry_t          q_reg [DEPTH];
    logic [CW-1:0]   cnt_reg;
    logic [2:0]      st_reg;
    cmd_t            cmd_reg;
    logic [CW-1:0]   i_reg, j_reg;
    logic [CW-1:0]   outer_reg;
    logic            found_reg;
    logic [1:0]      stat_reg;
    res_t            out_reg;
    logic            ov_reg;

    // shared compare unit, key match or sequence order
    entry_t          ea, eb;
    logic            key_hit, seq_gt;
    logic            free;
    logic            load_out;

    assign ea = q_reg[i_reg[IW-1:0]];
    assign eb = q_reg[j_reg[IW-1:0]];
    assign key_hit = (ea.sender == cmd_reg.sender_id) && (ea.message == cmd_reg.message_id);
    assign seq_gt = ea.seq > eb.seq;
    assign free = !ov_reg || !out_stall;
    assign load_out = free && ((st_reg == S_DRN && cnt_reg != '0 && q_reg[0].ready)
        || st_reg == S_OUT);

    assign in_stall = (st_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data = out_reg;

    function automatic res_t status(input logic [1:0] t);
        res_t r;
        r = '0;
        r.result_type = t;
        r.last = 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid && !in_stall && in_data.func == FUNC_PUT
            && cnt_reg < CW'(DEPTH))
        begin
            q_reg[cnt_reg[IW-1:0]] <= '{in_data.sender_id, in_data.message_id,
                in_data.seq_number, in_data.ready_in, in_data.kind_in, in_data.payload_handle};
        end
        else if (st_reg == S_REM && i_reg < cnt_reg && key_hit)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
                if (CW'(k) >= i_reg)
                    q_reg[k] <= q_reg[k+1];
        end
        else if (st_reg == S_FIND && i_reg < cnt_reg && key_hit)
        begin
            q_reg[i_reg[IW-1:0]].seq <= cmd_reg.seq_number;
            q_reg[i_reg[IW-1:0]].ready <= 1'b1;
        end
        else if (st_reg == S_SORT && j_reg != '0 && j_reg < cnt_reg && seq_gt)
        begin
            // j indexes the upper slot, i = j-1 holds the earlier entry; seq_gt means a > b
            q_reg[i_reg[IW-1:0]] <= eb;
            q_reg[j_reg[IW-1:0]] <= ea;
        end
        else if (st_reg == S_DRN && free && cnt_reg != '0 && q_reg[0].ready)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
                q_reg[k] <= q_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            outer_reg <= '0;
            found_reg <= 1'b0;
            stat_reg <= RES_DONE;
            cmd_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        cmd_reg <= in_data;
                        i_reg <= '0;
                        found_reg <= 1'b0;
                        case (in_data.func)
                            FUNC_PUT:
                            begin
                                if (cnt_reg < CW'(DEPTH))
                                begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                    stat_reg <= RES_DONE;
                                end
                                else
                                    stat_reg <= RES_FULL;
                                st_reg <= S_OUT;
                            end
                            FUNC_REMOVE: st_reg <= S_REM;
                            FUNC_UPDATE: st_reg <= S_FIND;
                            default:
                            begin
                                stat_reg <= RES_DONE;
                                st_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_REM:
                begin
                    if (i_reg >= cnt_reg)
                    begin
                        stat_reg <= RES_DONE;
                        st_reg <= S_OUT;
                    end
                    else if (key_hit)
                        cnt_reg <= cnt_reg - 1'b1;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_FIND:
                begin
                    if (i_reg < cnt_reg && key_hit)
                        found_reg <= 1'b1;
                    if (i_reg >= cnt_reg || key_hit)
                    begin
                        // insertion sort: j walks down from outer index, i = j-1
                        j_reg <= CW'(1);
                        i_reg <= '0;
                        outer_reg <= CW'(1);
                        st_reg <= S_SORT;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_SORT:
                begin
                    if (j_reg >= cnt_reg)
                        st_reg <= S_DRN;
                    else if (j_reg != '0 && seq_gt)
                    begin
                        j_reg <= j_reg - 1'b1;
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        // advance to next outer element
                        j_reg <= outer_reg + 1'b1;
                        i_reg <= outer_reg;
                        outer_reg <= outer_reg + 1'b1;
                    end
                end
                S_DRN:
                begin
                    if (free)
                    begin
                        if (cnt_reg != '0 && q_reg[0].ready)
                        begin
                            out_reg <= '{RES_DELIVER, q_reg[0].sender, q_reg[0].message,
                                q_reg[0].seq, q_reg[0].kind, q_reg[0].payload, 1'b0};
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        else
                        begin
                            stat_reg <= found_reg ? RES_DONE : RES_NOMATCH;
                            st_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (free)
                    begin
                        out_reg <= status(stat_reg);
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("entry count overflow");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> in_stall) else $error("accepting while busy");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_reg.last && !out_stall) |-> st_reg == S_IDLE)
        else $error("status word before command end");
endmodule
`default_nettype wire

// ===== sim/tb_total_order_holdback_queue.sv =====
`default_nettype none
module tb_total_order_holdback_queue;
    import tohq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEF;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    cmd_t in_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    res_t out_data;
    logic out_valid;
    logic out_stall = 1'b0;

    // sender-side model of the queue
    entry_t held_q[$];
    res_t expected_words[$];
    int mismatches = 0;
    int unexpected_words = 0;
    bit random_idle = 1'b0;
    bit hold_receiver = 1'b0;
    int idle_cycles = 0;

    total_order_holdback_queue #(.DEPTH(DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_data(in_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_data(out_data),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_t status_word(logic [1:0] kind);
        res_t w;
        w = '0;
        w.result_type = kind;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void expect_word(res_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void predict_command(cmd_t c);
        int i;
        int j;
        bit found;
        entry_t e;
        res_t w;
        found = 1'b0;
        case (c.func)
            FUNC_PUT:
            begin
                if (held_q.size() >= DEPTH)
                begin
                    expect_word(status_word(RES_FULL));
                end
                else
                begin
                    e.sender = c.sender_id;
                    e.message = c.message_id;
                    e.seq = c.seq_number;
                    e.ready = c.ready_in;
                    e.kind = c.kind_in;
                    e.payload = c.payload_handle;
                    held_q.insert(held_q.size(), e);
                    expect_word(status_word(RES_DONE));
                end
            end
            FUNC_REMOVE:
            begin
                i = 0;
                while (i < held_q.size())
                begin
                    if (held_q[i].sender == c.sender_id && held_q[i].message == c.message_id)
                        held_q.delete(i);
                    else
                        i++;
                end
                expect_word(status_word(RES_DONE));
            end
            FUNC_UPDATE:
            begin
                for (i = 0; i < held_q.size(); i++)
                begin
                    if (!found && held_q[i].sender == c.sender_id
                        && held_q[i].message == c.message_id)
                    begin
                        held_q[i].seq = c.seq_number;
                        held_q[i].ready = 1'b1;
                        found = 1'b1;
                    end
                end
                // stable insertion sort on sequence
                for (i = 1; i < held_q.size(); i++)
                begin
                    j = i;
                    while (j > 0 && held_q[j-1].seq > held_q[j].seq)
                    begin
                        e = held_q[j-1];
                        held_q[j-1] = held_q[j];
                        held_q[j] = e;
                        j--;
                    end
                end
                while (held_q.size() > 0 && held_q[0].ready)
                begin
                    w = '0;
                    w.result_type = RES_DELIVER;
                    w.out_sender = held_q[0].sender;
                    w.out_message = held_q[0].message;
                    w.out_seq = held_q[0].seq;
                    w.out_kind = held_q[0].kind;
                    w.out_payload = held_q[0].payload;
                    held_q.pop_front();
                    expect_word(w);
                end
                expect_word(status_word(found ? RES_DONE : RES_NOMATCH));
            end
            default:
            begin
                expect_word(status_word(RES_DONE));
            end
        endcase
    endfunction

    // valid stays high between back to back words; it drops only for an idle gap
    task automatic send_word(cmd_t c);
        int gap;
        if (random_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= c;
        in_valid <= 1'b1;
        predict_command(c);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // checker: compare each accepted word with oldest expectation
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                unexpected_words++;
                if (mismatches < 10)
                    $display("unexpected word %h", out_data);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (want !== out_data)
                begin
                    if (mismatches < 10)
                    begin
                        $write("mismatch: type %0d/%0d sender %h/%h msg %h/%h ",
                            want.result_type, out_data.result_type, want.out_sender,
                            out_data.out_sender, want.out_message, out_data.out_message);
                        $display("seq %h/%h kind %b/%b payload %h/%h last %b/%b",
                            want.out_seq, out_data.out_seq, want.out_kind, out_data.out_kind,
                            want.out_payload, out_data.out_payload, want.last, out_data.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // receiver stall: random bursts, or a long hold-off
    always @(posedge clk)
    begin
        int burst;
        if (hold_receiver)
            out_stall <= 1'b1;
        else if (burst > 0)
        begin
            burst--;
            out_stall <= 1'b1;
        end
        else if (random_idle && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(logic [1:0] f, logic [7:0] s, logic [15:0] m,
                                      logic [31:0] q, logic r, logic k, logic [15:0] p);
        cmd_t c;
        c.func = f;
        c.sender_id = s;
        c.message_id = m;
        c.seq_number = q;
        c.ready_in = r;
        c.kind_in = k;
        c.payload_handle = p;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        return make_cmd(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), $urandom,
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
    endfunction

    task automatic test_directed();
        int i;
        send_word(make_cmd(FUNC_UPDATE, 8'd1, 16'd1, 32'd5, 1'b0, 1'b0, 16'd0));
        send_word(make_cmd(FUNC_REMOVE, 8'd1, 16'd1, 32'd0, 1'b0, 1'b0, 16'd0));
        send_word(make_cmd(FUNC_PUT, 8'hff, 16'hffff, 32'hffffffff, 1'b0, 1'b1, 16'hffff));
        send_word(make_cmd(FUNC_PUT, 8'h00, 16'h0000, 32'h0, 1'b0, 1'b0, 16'h0));
        send_word(make_cmd(FUNC_PUT, 8'h00, 16'h0000, 32'h7, 1'b1, 1'b1, 16'h1234));
        send_word(make_cmd(2'd3, 8'h5a, 16'h5a5a, 32'h5a5a5a5a, 1'b1, 1'b1, 16'h5a5a));
        // tie on sequence keeps insertion order; duplicate ids updated first only
        send_word(make_cmd(FUNC_UPDATE, 8'h00, 16'h0000, 32'h7, 1'b0, 1'b0, 16'h0));
        send_word(make_cmd(FUNC_UPDATE, 8'hff, 16'hffff, 32'h0, 1'b0, 1'b0, 16'h0));
        // fill to overflow
        for (i = 0; i < DEPTH + 2; i++)
            send_word(make_cmd(FUNC_PUT, 8'd3, i[15:0], 32'd100 - i, i[0], i[1], i[15:0]));
        send_word(make_cmd(FUNC_REMOVE, 8'd3, 16'd4, 32'd0, 1'b0, 1'b0, 16'd0));
        send_word(make_cmd(FUNC_UPDATE, 8'd3, 16'd15, 32'd1, 1'b0, 1'b0, 16'd0));
    endtask

    task automatic test_random_traffic(int count);
        int n;
        int pick;
        cmd_t c;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4 || held_q.size() == 0)
                c = make_cmd(FUNC_PUT, 8'($urandom_range(0, 3)), 16'($urandom_range(0, 7)),
                    $urandom_range(0, 40), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 16'($urandom));
            else if (pick < 8)
            begin
                c = make_cmd(FUNC_UPDATE, 8'd0, 16'd0, $urandom_range(0, 40), 1'b0, 1'b0,
                    16'd0);
                pick = $urandom_range(0, held_q.size() - 1);
                c.sender_id = held_q[pick].sender;
                c.message_id = held_q[pick].message;
                if ($urandom_range(0, 7) == 0)
                    c.seq_number = $urandom;
            end
            else if (pick < 9)
            begin
                c = make_cmd(FUNC_REMOVE, 8'($urandom_range(0, 3)), 16'($urandom_range(0, 7)),
                    $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    16'($urandom));
            end
            else
                c = random_cmd();
            send_word(c);
        end
    endtask

    task automatic test_backpressure();
        int n;
        hold_receiver = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            for (n = 0; n < 12; n++)
                send_word(make_cmd(FUNC_PUT, 8'd9, n[15:0], $urandom_range(0, 50),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom)));
        join
        send_word(make_cmd(FUNC_UPDATE, 8'd9, 16'd0, 32'd0, 1'b0, 1'b0, 16'd0));
    endtask

    initial
    begin
        int tail;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        random_idle = 1'b1;
        test_random_traffic(200);
        test_backpressure();
        test_random_traffic(140);
        random_idle = 1'b0;
        test_random_traffic(60);
        in_valid <= 1'b0;
        tail = 0;
        while (expected_words.size() != 0 && tail < STALL_LIMIT)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && unexpected_words == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
